FILE: rtl/pmix_pkg.sv
// Shared types and constants for the palette RAM pixel mixer.
`default_nettype none
package pmix_pkg;

  localparam int PALETTE_BYTES = 64;
  localparam int PAL_ADDR_W    = $clog2(PALETTE_BYTES);
  localparam int BANK_DEPTH    = PALETTE_BYTES / 2;
  localparam int BANK_ADDR_W   = $clog2(BANK_DEPTH);

  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W    = 24;
  localparam int IN_TUSER_W    = 4;
  localparam int OUT_TDATA_W   = 24;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 8;

  localparam logic [15:0] WHITE_COLOR  = 16'h7FFF;
  localparam logic [7:0]  BLOCKED_READ = 8'hFF;

  typedef enum logic [3:0] {
    FN_COMPOSE   = 4'd0,
    FN_BG_IDX_WR = 4'd1,
    FN_BG_DAT_WR = 4'd2,
    FN_BG_DAT_RD = 4'd3,
    FN_OB_IDX_WR = 4'd4,
    FN_OB_DAT_WR = 4'd5,
    FN_OB_DAT_RD = 4'd6,
    FN_BG_IDX_RD = 4'd7,
    FN_OB_IDX_RD = 4'd8
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COMPAT     = 3'd0,
    CFG_BG_WIN_EN  = 3'd1,
    CFG_BG_MASTER  = 3'd2,
    CFG_BG_MONO    = 3'd3,
    CFG_OBJ_MONO0  = 3'd4,
    CFG_OBJ_MONO1  = 3'd5
  } cfg_reg_t;

  // What the back end does with a request.
  typedef enum logic [1:0] {
    OP_CONST = 2'd0,
    OP_BYTE  = 2'd1,
    OP_WORD  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  use_bg;
    logic [PAL_ADDR_W-1:0] addr;
    logic                  we;
    logic [7:0]            wdata;
    logic [15:0]           pix;
    logic [7:0]            rd;
  } pmix_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/pmix_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module pmix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/pmix_front.sv
// Front end: configuration registers, index registers and request classification.
`default_nettype none
module pmix_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [pmix_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [pmix_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire logic                              cfg_valid,
  input  wire logic [pmix_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [pmix_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output pmix_pkg::pmix_cmd_t                    q_cmd
);
  import pmix_pkg::*;

  logic       compat_r, bg_win_en_r, bg_master_r;
  logic [7:0] bg_mono_r, obj_mono0_r, obj_mono1_r;
  logic [7:0] bg_idx_r, bg_idx_nxt, obj_idx_r, obj_idx_nxt;

  logic [7:0] bus_data;
  logic       rendering, bg_priority, obj_behind, obj_sel1;
  logic [1:0] bg_color, obj_color, bg_shade, obj_shade;
  logic [2:0] bg_pal, obj_pal, obj_pal_eff;
  logic       bg_on, ob_on;
  logic [7:0] obj_mono;
  func_t      func;
  logic       accept;

  assign bus_data    = in_tdata[7:0];
  assign rendering   = in_tdata[8];
  assign bg_color    = in_tdata[10:9];
  assign bg_pal      = in_tdata[13:11];
  assign bg_priority = in_tdata[14];
  assign obj_color   = in_tdata[16:15];
  assign obj_pal     = in_tdata[19:17];
  assign obj_behind  = in_tdata[20];
  assign obj_sel1    = in_tdata[21];
  assign func        = func_t'(in_tuser);

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;

  function automatic logic [7:0] inc_index(input logic [7:0] idx);
    logic [7:0] r;
    r = idx;
    if (idx[7]) begin
      r = {2'b10, idx[5:0] + 6'd1};
    end
    return r;
  endfunction

  // Layer selection and legacy shade remap for a compose request.
  always_comb begin
    bg_on = !compat_r || bg_win_en_r;
    ob_on = (obj_color != 2'd0);
    if (bg_on && ob_on && !compat_r && !bg_master_r) begin
      bg_on = 1'b0;
    end else if (bg_on && ob_on && (bg_priority || obj_behind) && (bg_color != 2'd0)) begin
      ob_on = 1'b0;
    end
    obj_mono    = obj_sel1 ? obj_mono1_r : obj_mono0_r;
    obj_shade   = compat_r ? obj_mono[{obj_color, 1'b0} +: 2] : obj_color;
    obj_pal_eff = compat_r ? {2'b00, obj_sel1} : obj_pal;
    bg_shade    = compat_r ? bg_mono_r[{bg_color, 1'b0} +: 2] : bg_color;
  end

  always_comb begin
    q_cmd       = '0;
    q_cmd.op    = OP_CONST;
    q_cmd.wdata = bus_data;
    bg_idx_nxt  = bg_idx_r;
    obj_idx_nxt = obj_idx_r;
    case (func)
      FN_COMPOSE: begin
        if (ob_on) begin
          q_cmd.op   = OP_WORD;
          q_cmd.addr = {obj_pal_eff, obj_shade, 1'b0};
        end else if (bg_on) begin
          q_cmd.op     = OP_WORD;
          q_cmd.use_bg = 1'b1;
          q_cmd.addr   = {bg_pal, bg_shade, 1'b0};
        end else begin
          q_cmd.pix = WHITE_COLOR;
        end
      end
      FN_BG_IDX_WR: bg_idx_nxt = bus_data;
      FN_BG_DAT_WR: begin
        q_cmd.use_bg = 1'b1;
        q_cmd.addr   = bg_idx_r[PAL_ADDR_W-1:0];
        q_cmd.we     = !rendering;
        bg_idx_nxt   = inc_index(bg_idx_r);
      end
      FN_BG_DAT_RD: begin
        q_cmd.use_bg = 1'b1;
        q_cmd.addr   = bg_idx_r[PAL_ADDR_W-1:0];
        if (rendering) begin
          q_cmd.rd = BLOCKED_READ;
        end else begin
          q_cmd.op = OP_BYTE;
        end
      end
      FN_OB_IDX_WR: obj_idx_nxt = bus_data;
      FN_OB_DAT_WR: begin
        q_cmd.addr  = obj_idx_r[PAL_ADDR_W-1:0];
        q_cmd.we    = !rendering;
        obj_idx_nxt = inc_index(obj_idx_r);
      end
      FN_OB_DAT_RD: begin
        q_cmd.addr = obj_idx_r[PAL_ADDR_W-1:0];
        if (rendering) begin
          q_cmd.rd = BLOCKED_READ;
        end else begin
          q_cmd.op = OP_BYTE;
        end
      end
      FN_BG_IDX_RD: q_cmd.rd = bg_idx_r;
      FN_OB_IDX_RD: q_cmd.rd = obj_idx_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compat_r    <= 1'b0;
      bg_win_en_r <= 1'b0;
      bg_master_r <= 1'b0;
      bg_mono_r   <= '0;
      obj_mono0_r <= '0;
      obj_mono1_r <= '0;
      bg_idx_r    <= '0;
      obj_idx_r   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          CFG_COMPAT:    compat_r    <= cfg_data[0];
          CFG_BG_WIN_EN: bg_win_en_r <= cfg_data[0];
          CFG_BG_MASTER: bg_master_r <= cfg_data[0];
          CFG_BG_MONO:   bg_mono_r   <= cfg_data;
          CFG_OBJ_MONO0: obj_mono0_r <= cfg_data;
          CFG_OBJ_MONO1: obj_mono1_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        bg_idx_r  <= bg_idx_nxt;
        obj_idx_r <= obj_idx_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pmix_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none
module pmix_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire pmix_pkg::pmix_cmd_t push_cmd,
  output logic                     full,
  input  wire logic                pop,
  output pmix_pkg::pmix_cmd_t      pop_cmd,
  output logic                     empty
);
  import pmix_pkg::*;

  pmix_cmd_t              entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;

  assign full    = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pmix_back.sv
// Back end: palette memories, their valid bits, and the result register.
`default_nettype none
module pmix_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_empty,
  input  wire pmix_pkg::pmix_cmd_t               q_cmd,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [pmix_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import pmix_pkg::*;

  // Each palette is split into even and odd byte banks so a colour word
  // comes out of one read.
  logic [BANK_DEPTH-1:0]  bg_lo_v_r, bg_hi_v_r, ob_lo_v_r, ob_hi_v_r;
  logic [BANK_ADDR_W-1:0] waddr;
  logic                   bg_lo_we, bg_hi_we, ob_lo_we, ob_hi_we;
  logic [7:0]             bg_lo_q, bg_hi_q, ob_lo_q, ob_hi_q;

  logic       s1_valid_r;
  op_t        s1_op_r;
  logic       s1_use_bg_r, s1_odd_r, s1_lo_v_r, s1_hi_v_r;
  logic [15:0] s1_pix_r;
  logic [7:0]  s1_rd_r;
  logic        s1_adv;

  logic        out_valid_r;
  logic [15:0] out_pix_r, res_pix;
  logic [7:0]  out_rd_r, res_rd, lo_byte, hi_byte;
  logic        lo_v_now, hi_v_now;

  assign waddr  = q_cmd.addr[PAL_ADDR_W-1:1];
  assign s1_adv = s1_valid_r && (!out_valid_r || out_tready);
  assign q_pop  = !q_empty && (!s1_valid_r || s1_adv);

  assign bg_lo_we = q_pop && q_cmd.we && q_cmd.use_bg && !q_cmd.addr[0];
  assign bg_hi_we = q_pop && q_cmd.we && q_cmd.use_bg && q_cmd.addr[0];
  assign ob_lo_we = q_pop && q_cmd.we && !q_cmd.use_bg && !q_cmd.addr[0];
  assign ob_hi_we = q_pop && q_cmd.we && !q_cmd.use_bg && q_cmd.addr[0];

  assign lo_v_now = q_cmd.use_bg ? bg_lo_v_r[waddr] : ob_lo_v_r[waddr];
  assign hi_v_now = q_cmd.use_bg ? bg_hi_v_r[waddr] : ob_hi_v_r[waddr];

  pmix_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bg_lo (
    .clk(clk), .we(bg_lo_we), .waddr(waddr), .wdata(q_cmd.wdata),
    .re(q_pop), .raddr(waddr), .rdata(bg_lo_q)
  );
  pmix_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bg_hi (
    .clk(clk), .we(bg_hi_we), .waddr(waddr), .wdata(q_cmd.wdata),
    .re(q_pop), .raddr(waddr), .rdata(bg_hi_q)
  );
  pmix_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ob_lo (
    .clk(clk), .we(ob_lo_we), .waddr(waddr), .wdata(q_cmd.wdata),
    .re(q_pop), .raddr(waddr), .rdata(ob_lo_q)
  );
  pmix_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ob_hi (
    .clk(clk), .we(ob_hi_we), .waddr(waddr), .wdata(q_cmd.wdata),
    .re(q_pop), .raddr(waddr), .rdata(ob_hi_q)
  );

  // A byte never written since reset reads as zero.
  always_comb begin
    lo_byte = '0;
    hi_byte = '0;
    if (s1_lo_v_r) begin
      lo_byte = s1_use_bg_r ? bg_lo_q : ob_lo_q;
    end
    if (s1_hi_v_r) begin
      hi_byte = s1_use_bg_r ? bg_hi_q : ob_hi_q;
    end
    res_pix = s1_pix_r;
    res_rd  = s1_rd_r;
    case (s1_op_r)
      OP_WORD: res_pix = {hi_byte, lo_byte};
      OP_BYTE: res_rd  = s1_odd_r ? hi_byte : lo_byte;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op_r     <= q_cmd.op;
      s1_use_bg_r <= q_cmd.use_bg;
      s1_odd_r    <= q_cmd.addr[0];
      s1_lo_v_r   <= lo_v_now;
      s1_hi_v_r   <= hi_v_now;
      s1_pix_r    <= q_cmd.pix;
      s1_rd_r     <= q_cmd.rd;
    end
    if (s1_adv) begin
      out_pix_r <= res_pix;
      out_rd_r  <= res_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bg_lo_v_r   <= '0;
      bg_hi_v_r   <= '0;
      ob_lo_v_r   <= '0;
      ob_hi_v_r   <= '0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (bg_lo_we) bg_lo_v_r[waddr] <= 1'b1;
      if (bg_hi_we) bg_hi_v_r[waddr] <= 1'b1;
      if (ob_lo_we) ob_lo_v_r[waddr] <= 1'b1;
      if (ob_hi_we) ob_hi_v_r[waddr] <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rd_r, out_pix_r};

endmodule
`default_nettype wire

FILE: rtl/palette_ram_pixel_mixer_unit.sv
// Top level of the palette RAM pixel mixer.
// Every request yields exactly one result: a composed colour word for a compose
// request, or a byte for an index or palette read, and zeros otherwise. The
// block sustains one request per clock while results are taken; a result is
// offered once its request has passed the queue entry, written at the edge that
// takes it, then the registered read of the palette memories and the result
// register. A two-entry request queue lets the input side keep going while a
// result waits to be taken. The palettes read as zero after reset through
// per-byte valid bits, so no clearing pass is needed. Configuration writes are
// always taken and go to the register named by cfg_index.
`default_nettype none
module palette_ram_pixel_mixer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [7:0] bus_data, [8] rendering, [10:9] bg_color, [13:11] bg_palette,
  // [14] bg_priority, [16:15] obj_color, [19:17] obj_palette,
  // [20] obj_behind_bg, [21] obj_mono_select, [23:22] zero
  input  wire logic [pmix_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [3:0] func
  input  wire logic [pmix_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [15:0] pixel_color, [23:16] read_data
  output logic [pmix_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pmix_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pmix_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pmix_pkg::*;

  pmix_cmd_t push_cmd, pop_cmd;
  logic      q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  pmix_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(q_full), .q_push(q_push), .q_cmd(push_cmd)
  );

  pmix_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_cmd(push_cmd), .full(q_full),
    .pop(q_pop), .pop_cmd(pop_cmd), .empty(q_empty)
  );

  pmix_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_cmd(pop_cmd), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

FILE: dv/palette_ram_pixel_mixer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the palette RAM pixel mixer: predicts every result and compares it.
module palette_ram_pixel_mixer_unit_tb;
  import pmix_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 100;
  localparam int MAX_REPORTS   = 20;
  localparam int IDX_AUTO_INC  = 7;
  localparam logic [3:0] FUNC_UNUSED_LO = FN_OB_IDX_RD + 4'd1;
  localparam logic [3:0] FUNC_UNUSED_HI = 4'hF;

  typedef struct packed {
    logic [3:0] func;
    logic       obj_mono_select;
    logic       obj_behind_bg;
    logic [2:0] obj_palette;
    logic [1:0] obj_color;
    logic       bg_priority;
    logic [2:0] bg_palette;
    logic [1:0] bg_color;
    logic       rendering;
    logic [7:0] bus_data;
  } mix_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pixel_color;
  } mix_result_t;

  class pixel_mixer_tracker;
    logic [7:0]  bg_ram [PALETTE_BYTES];
    logic [7:0]  obj_ram [PALETTE_BYTES];
    logic [7:0]  bg_idx;
    logic [7:0]  obj_idx;
    logic        compat;
    logic        win_en;
    logic        master;
    logic [7:0]  bg_mono;
    logic [7:0]  obj_mono0;
    logic [7:0]  obj_mono1;
    mix_result_t pending_results[$];
    int          errors;
    int          checked;
    int          requests;
    int          composes;
    int          reads;

    function new();
      foreach (bg_ram[i]) begin
        bg_ram[i]  = '0;
        obj_ram[i] = '0;
      end
      bg_idx    = '0;
      obj_idx   = '0;
      compat    = 1'b0;
      win_en    = 1'b0;
      master    = 1'b0;
      bg_mono   = '0;
      obj_mono0 = '0;
      obj_mono1 = '0;
      errors    = 0;
      checked   = 0;
      requests  = 0;
      composes  = 0;
      reads     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [7:0] val);
      case (idx)
        CFG_COMPAT:    compat    = val[0];
        CFG_BG_WIN_EN: win_en    = val[0];
        CFG_BG_MASTER: master    = val[0];
        CFG_BG_MONO:   bg_mono   = val;
        CFG_OBJ_MONO0: obj_mono0 = val;
        CFG_OBJ_MONO1: obj_mono1 = val;
        default: ;
      endcase
    endfunction

    // With auto-increment on, bit 6 is cleared and the address wraps.
    function logic [7:0] next_index(logic [7:0] idx);
      logic [7:0] nxt;
      nxt = idx;
      if (idx[IDX_AUTO_INC]) begin
        nxt = '0;
        nxt[IDX_AUTO_INC] = 1'b1;
        nxt[PAL_ADDR_W-1:0] = idx[PAL_ADDR_W-1:0] + 1'b1;
      end
      return nxt;
    endfunction

    function logic [15:0] color_at(logic from_obj, logic [2:0] pal, logic [1:0] shade);
      logic [PAL_ADDR_W-1:0] lo_addr;
      lo_addr = {pal, shade, 1'b0};
      if (from_obj)
        return {obj_ram[lo_addr + 1'b1], obj_ram[lo_addr]};
      return {bg_ram[lo_addr + 1'b1], bg_ram[lo_addr]};
    endfunction

    function logic [15:0] mix_pixel(mix_req_t r);
      logic       bg_on;
      logic       ob_on;
      logic [1:0] shade;
      logic [2:0] pal;
      logic [7:0] mono;
      bg_on = !compat || win_en;
      ob_on = (r.obj_color != 2'd0);
      if (bg_on && ob_on && !compat && !master)
        bg_on = 1'b0;
      else if (bg_on && ob_on && (r.bg_priority || r.obj_behind_bg) && r.bg_color != 2'd0)
        ob_on = 1'b0;
      if (ob_on) begin
        shade = r.obj_color;
        pal   = r.obj_palette;
        if (compat) begin
          mono  = r.obj_mono_select ? obj_mono1 : obj_mono0;
          shade = mono[{r.obj_color, 1'b0} +: 2];
          pal   = {2'b00, r.obj_mono_select};
        end
        return color_at(1'b1, pal, shade);
      end
      if (bg_on) begin
        shade = r.bg_color;
        if (compat)
          shade = bg_mono[{r.bg_color, 1'b0} +: 2];
        return color_at(1'b0, r.bg_palette, shade);
      end
      return WHITE_COLOR;
    endfunction

    function void take_request(mix_req_t r);
      mix_result_t res;
      res = '0;
      requests++;
      case (r.func)
        FN_COMPOSE: begin
          res.pixel_color = mix_pixel(r);
          composes++;
        end
        FN_BG_IDX_WR: bg_idx = r.bus_data;
        FN_BG_DAT_WR: begin
          if (!r.rendering)
            bg_ram[bg_idx[PAL_ADDR_W-1:0]] = r.bus_data;
          bg_idx = next_index(bg_idx);
        end
        FN_BG_DAT_RD: begin
          res.read_data = r.rendering ? BLOCKED_READ : bg_ram[bg_idx[PAL_ADDR_W-1:0]];
          reads++;
        end
        FN_OB_IDX_WR: obj_idx = r.bus_data;
        FN_OB_DAT_WR: begin
          if (!r.rendering)
            obj_ram[obj_idx[PAL_ADDR_W-1:0]] = r.bus_data;
          obj_idx = next_index(obj_idx);
        end
        FN_OB_DAT_RD: begin
          res.read_data = r.rendering ? BLOCKED_READ : obj_ram[obj_idx[PAL_ADDR_W-1:0]];
          reads++;
        end
        FN_BG_IDX_RD: begin
          res.read_data = bg_idx;
          reads++;
        end
        FN_OB_IDX_RD: begin
          res.read_data = obj_idx;
          reads++;
        end
        default: ;
      endcase
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void report(string what, logic [15:0] want, logic [15:0] seen);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, seen);
    endfunction

    function void match_result(logic [OUT_TDATA_W-1:0] data);
      mix_result_t got;
      mix_result_t want;
      got = data;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request outstanding, expected none, got %h",
                   $time, data);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.pixel_color !== want.pixel_color)
        report("pixel_color", want.pixel_color, got.pixel_color);
      if (got.read_data !== want.read_data)
        report("read_data", {8'h00, want.read_data}, {8'h00, got.read_data});
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  pixel_mixer_tracker tracker;
  bit allow_gaps    = 1'b1;
  int sent          = 0;
  int settings_used = 0;

  palette_ram_pixel_mixer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic mix_req_t make_req(logic [3:0] f, logic [7:0] d, logic rend);
    mix_req_t    r;
    logic [31:0] bits;
    bits = $urandom;
    r = bits[$bits(mix_req_t)-1:0];
    r.func      = f;
    r.bus_data  = d;
    r.rendering = rend;
    return r;
  endfunction

  task automatic send_req(mix_req_t r);
    int gap;
    gap = allow_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.func;
    in_tdata  <= {2'b00, r.obj_mono_select, r.obj_behind_bg, r.obj_palette, r.obj_color,
                  r.bg_priority, r.bg_palette, r.bg_color, r.rendering, r.bus_data};
    do @(posedge clk); while (!in_tready);
    tracker.take_request(r);
    if (r.func <= FN_OB_IDX_RD)
      sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_settings(logic c, logic w, logic m, logic [7:0] bgm, logic [7:0] o0,
                                logic [7:0] o1);
    wait_idle();
    write_reg(CFG_COMPAT, {7'd0, c});
    write_reg(CFG_BG_WIN_EN, {7'd0, w});
    write_reg(CFG_BG_MASTER, {7'd0, m});
    write_reg(CFG_BG_MONO, bgm);
    write_reg(CFG_OBJ_MONO0, o0);
    write_reg(CFG_OBJ_MONO1, o1);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One burst of related requests: palette loads, read-backs, pixel runs or noise.
  task automatic run_sequence();
    int         kind;
    int         n;
    logic       side;
    logic [3:0] f_idx_wr;
    logic [3:0] f_dat_wr;
    logic [3:0] f_dat_rd;
    logic [3:0] f_idx_rd;
    mix_req_t   r;
    allow_gaps = ($urandom_range(0, 3) != 0);
    side       = 1'($urandom);
    f_idx_wr   = side ? FN_OB_IDX_WR : FN_BG_IDX_WR;
    f_dat_wr   = side ? FN_OB_DAT_WR : FN_BG_DAT_WR;
    f_dat_rd   = side ? FN_OB_DAT_RD : FN_BG_DAT_RD;
    f_idx_rd   = side ? FN_OB_IDX_RD : FN_BG_IDX_RD;
    kind       = $urandom_range(0, 9);
    n          = $urandom_range(1, 8);
    if (kind <= 2) begin
      r = make_req(f_idx_wr, 8'($urandom), 1'b0);
      r.bus_data[IDX_AUTO_INC] = ($urandom_range(0, 7) != 0);
      send_req(r);
      repeat (n) send_req(make_req(f_dat_wr, 8'($urandom), $urandom_range(0, 7) == 0));
    end else if (kind == 3) begin
      send_req(make_req(f_idx_wr, 8'($urandom), 1'b0));
      repeat (n)
        send_req(make_req(($urandom_range(0, 3) == 0) ? f_idx_rd : f_dat_rd, 8'($urandom),
                          $urandom_range(0, 5) == 0));
    end else if (kind <= 7) begin
      repeat (n + 4) send_req(make_req(FN_COMPOSE, 8'($urandom), 1'($urandom)));
    end else if (kind == 8) begin
      repeat ((n + 1) / 2) send_req(make_req(4'($urandom), 8'($urandom), 1'($urandom)));
    end else begin
      repeat (n)
        send_req(make_req(4'($urandom_range(0, FN_OB_IDX_RD)), 8'($urandom), 1'($urandom)));
    end
  endtask

  initial begin : stimulus
    mix_req_t r;
    int       phase;
    int       quota;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: colour mode with sprites always on top.
    r = make_req(FN_COMPOSE, 8'h00, 1'b0);
    r.bg_color = 2'd3;
    r.bg_palette = 3'd7;
    r.bg_priority = 1'b1;
    r.obj_color = 2'd0;
    send_req(r);
    send_req(make_req(FN_BG_DAT_RD, 8'h00, 1'b0));
    send_req(make_req(FN_BG_IDX_WR, 8'h80, 1'b0));
    send_req(make_req(FN_BG_DAT_WR, 8'hFF, 1'b0));
    send_req(make_req(FN_BG_DAT_WR, 8'h00, 1'b0));
    send_req(make_req(FN_BG_IDX_WR, 8'hBE, 1'b0));
    send_req(make_req(FN_BG_DAT_WR, 8'hA5, 1'b0));
    // This one lands on the last byte and wraps the address back to zero.
    send_req(make_req(FN_BG_DAT_WR, 8'h5A, 1'b0));
    send_req(make_req(FN_BG_IDX_RD, 8'h00, 1'b1));
    send_req(make_req(FN_OB_IDX_WR, 8'hFF, 1'b0));
    send_req(make_req(FN_OB_DAT_WR, 8'h7E, 1'b0));
    send_req(make_req(FN_OB_DAT_WR, 8'h11, 1'b1));
    send_req(make_req(FN_OB_IDX_RD, 8'h00, 1'b0));
    send_req(make_req(FN_OB_IDX_WR, 8'h3F, 1'b0));
    send_req(make_req(FN_OB_DAT_WR, 8'h22, 1'b0));
    send_req(make_req(FN_OB_DAT_WR, 8'h33, 1'b0));
    send_req(make_req(FN_OB_DAT_RD, 8'h00, 1'b0));
    send_req(make_req(FN_OB_DAT_RD, 8'h00, 1'b1));
    r = make_req(FN_COMPOSE, 8'hFF, 1'b1);
    r.obj_color = 2'd3;
    r.obj_palette = 3'd7;
    r.bg_color = 2'd3;
    r.bg_priority = 1'b1;
    r.obj_behind_bg = 1'b1;
    send_req(r);
    r = make_req(FN_COMPOSE, 8'h00, 1'b0);
    r.obj_color = 2'd1;
    r.obj_palette = 3'd0;
    r.bg_color = 2'd0;
    send_req(r);
    send_req(make_req(FUNC_UNUSED_LO, 8'hFF, 1'b1));
    send_req(make_req(FUNC_UNUSED_HI, 8'hFF, 1'b0));
    send_req(make_req(FN_BG_DAT_RD, 8'h00, 1'b0));

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_settings(1'b0, 1'b0, 1'b1, 8'hE4, 8'h1B, 8'hFF);
        1: apply_settings(1'b1, 1'b1, 1'b0, 8'hFF, 8'h00, 8'hE4);
        2: apply_settings(1'b1, 1'b0, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        3: apply_settings(1'b0, 1'b1, 1'b0, 8'h00, 8'hFF, 8'h00);
        4: apply_settings(1'b1, 1'b1, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        default: apply_settings(1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom));
      endcase
      quota = sent + PHASE_ITEMS;
      while (sent < quota) run_sequence();
    end

    wait_idle();
    $display("Covered %0d requests (%0d pixel composes, %0d reads) under %0d register settings.",
             tracker.requests, tracker.composes, tracker.reads, settings_used + 1);
    $display("Compared %0d results, found %0d errors.", tracker.checked, tracker.errors);
    if (tracker.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Result side: random back-pressure drawn after every accepted result.
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        tracker.match_result(out_tdata);
        stall = allow_gaps ? $urandom_range(0, 7) : 0;
      end
      out_tready <= (stall == 0);
      if (stall > 0)
        stall--;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
             tracker.pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pmix_pkg.sv
rtl/pmix_ram.sv
rtl/pmix_front.sv
rtl/pmix_queue.sv
rtl/pmix_back.sv
rtl/palette_ram_pixel_mixer_unit.sv
dv/palette_ram_pixel_mixer_unit_tb.sv
